// File: sv/lbb_pkg.sv
// Shared types and constants for the LRU byte-budget cache table.
// No dependencies; every other file imports this package.
package lbb_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 256;
  localparam int WORD_W    = 64;
  localparam int SIZE_BITS = 40;
  localparam int OBJ_W     = 40;
  localparam int TOTAL_W   = 45;
  localparam int LIMIT_W   = 21;
  localparam int MIB_SHIFT = 20;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [1:0] STATUS_HELD     = 2'd0;
  localparam logic [1:0] STATUS_ZERO_KEY = 2'd1;
  localparam logic [1:0] STATUS_TOOSMALL = 2'd2;

  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  localparam logic [0:0] REG_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_FULL,
    ST_PLACE,
    ST_TRIM,
    ST_CLOSE
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic [SIZE_BITS-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 place;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [CNT_W-1:0]     count;
    logic                 drop;
    logic [KEY_W-1:0]     new_key;
    logic [SIZE_BITS-1:0] new_bytes;
  } chain_cmd_t;

endpackage

// File: sv/lbb_ifs.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on lbb_pkg for field widths.
interface lbb_req_if import lbb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] key_w0;
  logic [WORD_W-1:0] key_w1;
  logic [WORD_W-1:0] key_w2;
  logic [WORD_W-1:0] key_w3;
  logic [OBJ_W-1:0]  object_bytes;

  modport source (output valid, key_w0, key_w1, key_w2, key_w3, object_bytes, input ready);
  modport sink   (input valid, key_w0, key_w1, key_w2, key_w3, object_bytes, output ready);
endinterface

interface lbb_rsp_if import lbb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [WORD_W-1:0]  out_w0;
  logic [WORD_W-1:0]  out_w1;
  logic [WORD_W-1:0]  out_w2;
  logic [WORD_W-1:0]  out_w3;
  logic [1:0]         status;
  logic [TOTAL_W-1:0] total_bytes;
  logic               last;

  modport source (output valid, kind, out_w0, out_w1, out_w2, out_w3, status, total_bytes,
                  last, input ready);
  modport sink   (input valid, kind, out_w0, out_w1, out_w2, out_w3, status, total_bytes,
                  last, output ready);
endinterface

// File: sv/lbb_cell.sv
// One table cell: holds a key and its size, compares against the lookup key.
// Depends on lbb_pkg.
module lbb_cell import lbb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  entry_t           prev,
  input  logic [KEY_W-1:0] key_in,
  output entry_t           cur,
  output logic             match
);

  logic                 valid;
  logic [KEY_W-1:0]     key;
  logic [SIZE_BITS-1:0] bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= prev.valid;
    end else if (ctrl.clr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key   <= prev.key;
      bytes <= prev.bytes;
    end
  end

  assign cur   = '{valid: valid, key: key, bytes: bytes};
  assign match = valid && (key == key_in);

endmodule

// File: sv/lbb_chain.sv
// Recency-ordered row of cells: cell 0 is most recent, valid cells are packed.
// Depends on lbb_pkg and lbb_cell.
module lbb_chain import lbb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  chain_cmd_t           cmd,
  output logic                 hit,
  output logic [IDX_W-1:0]     hit_idx,
  output logic [SIZE_BITS-1:0] hit_bytes,
  output logic [KEY_W-1:0]     lru_key,
  output logic [SIZE_BITS-1:0] lru_bytes
);

  entry_t           cur   [ENTRIES];
  entry_t           prev  [ENTRIES];
  cell_ctrl_t       ctrl  [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic [CNT_W-1:0] lru_cnt;
  logic [IDX_W-1:0] lru_idx;

  assign lru_cnt = cmd.count - CNT_W'(1);
  assign lru_idx = lru_cnt[IDX_W-1:0];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev[i] = '{valid: 1'b1, key: cmd.new_key, bytes: cmd.new_bytes};
    end else begin : g_body
      assign prev[i] = cur[i-1];
    end

    // Shift from the head up to the hit cell, or up to the first free cell.
    assign ctrl[i].shift = cmd.place &&
                           (cmd.hit ? (IDX_W'(i) <= cmd.hit_idx) : (CNT_W'(i) <= cmd.count));
    assign ctrl[i].clr   = cmd.drop && (IDX_W'(i) == lru_idx);

    lbb_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl[i]),
      .prev   (prev[i]),
      .key_in (cmd.new_key),
      .cur    (cur[i]),
      .match  (match[i])
    );
  end

  // Keys are unique in the table, so at most one cell matches.
  always_comb begin
    hit_idx   = '0;
    hit_bytes = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_bytes = hit_bytes | cur[i].bytes;
      end
    end
  end

  assign hit       = |match;
  assign lru_key   = cur[lru_idx].key;
  assign lru_bytes = cur[lru_idx].bytes;

endmodule

// File: sv/lru_byte_budget_cache_table.sv
// LRU byte-budget cache table: top level with sequencer and APB register.
// Sequence: an accepted request steps through MATCH, FULL (a miss on a full table), PLACE, TRIM
// (held while over budget, one reported eviction per handshake) and CLOSE; a zero key goes to CLOSE.
// Only one transaction is in flight; a new request is taken only in IDLE.
// Reset (rst, synchronous): table empty, total zero, limit zero; no clearing pass.
module lru_byte_budget_cache_table import lbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lbb_req_if.sink           req,
  lbb_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  state_t state, state_next;

  // Captured request
  logic [KEY_W-1:0]     key;
  logic [SIZE_BITS-1:0] obj;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic [SIZE_BITS-1:0] hit_bytes;
  logic [1:0]           status;

  // Table bookkeeping
  logic [CNT_W-1:0]   count;
  logic [TOTAL_W-1:0] total;
  logic [LIMIT_W-1:0] limit_mib;

  chain_cmd_t           cmd;
  logic                 c_hit;
  logic [IDX_W-1:0]     c_hit_idx;
  logic [SIZE_BITS-1:0] c_hit_bytes;
  logic [KEY_W-1:0]     lru_key;
  logic [SIZE_BITS-1:0] lru_bytes;

  logic               req_fire;
  logic               rsp_fire;
  logic               over;
  logic               drop;
  logic [TOTAL_W-1:0] budget;
  logic [TOTAL_W-1:0] total_after_drop;
  logic [KEY_W-1:0]   in_key;

  assign in_key   = {req.key_w3, req.key_w2, req.key_w1, req.key_w0};
  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;

  // ---------------- APB register ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_mib <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
      limit_mib <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LIMIT) ? DATA_W'(limit_mib) : '0;

  // ---------------- Budget check ----------------
  assign budget           = TOTAL_W'({limit_mib, MIB_SHIFT'(0)});
  assign over             = (limit_mib != '0) && (total > budget);
  assign total_after_drop = total - TOTAL_W'(lru_bytes);

  // ---------------- Table ----------------
  // Drop the LRU cell when a full-table or budget eviction is taken, or when the
  // new key itself is the only entry left over budget.
  always_comb begin
    drop = 1'b0;
    case (state)
      ST_FULL: drop = rsp_fire;
      ST_TRIM: drop = over && ((count > CNT_W'(1)) ? rsp_fire : 1'b1);
      default: drop = 1'b0;
    endcase
  end

  assign cmd = '{place:     (state == ST_PLACE),
                 hit:       hit,
                 hit_idx:   hit_idx,
                 count:     count,
                 drop:      drop,
                 new_key:   key,
                 new_bytes: hit ? hit_bytes : obj};

  lbb_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .hit       (c_hit),
    .hit_idx   (c_hit_idx),
    .hit_bytes (c_hit_bytes),
    .lru_key   (lru_key),
    .lru_bytes (lru_bytes)
  );

  // ---------------- Sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = (in_key == '0) ? ST_CLOSE : ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_next = (!c_hit && (count == CNT_W'(ENTRIES))) ? ST_FULL : ST_PLACE;
      end
      ST_FULL: begin
        if (rsp_fire) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: state_next = ST_TRIM;
      ST_TRIM: begin
        if (!over || (count <= CNT_W'(1))) begin
          state_next = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (rsp_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (drop) begin
      count <= count - CNT_W'(1);
      total <= total_after_drop;
    end else if ((state == ST_PLACE) && !hit) begin
      count <= count + CNT_W'(1);
      total <= total + TOTAL_W'(obj);
    end
  end

  // Request capture and closing status
  always_ff @(posedge clk) begin
    if (req_fire) begin
      key    <= in_key;
      obj    <= req.object_bytes[SIZE_BITS-1:0];
      status <= (in_key == '0) ? STATUS_ZERO_KEY : STATUS_HELD;
    end
    if (state == ST_MATCH) begin
      hit       <= c_hit;
      hit_idx   <= c_hit_idx;
      hit_bytes <= c_hit_bytes;
    end
    if ((state == ST_TRIM) && over && (count <= CNT_W'(1))) begin
      status <= STATUS_TOOSMALL;
    end
  end

  // ---------------- Outputs ----------------
  assign req.ready = (state == ST_IDLE);

  always_comb begin
    rsp.valid       = 1'b0;
    rsp.kind        = KIND_EVICT;
    rsp.status      = STATUS_HELD;
    rsp.total_bytes = total_after_drop;
    rsp.last        = 1'b0;
    {rsp.out_w3, rsp.out_w2, rsp.out_w1, rsp.out_w0} = lru_key;
    case (state)
      ST_FULL: rsp.valid = 1'b1;
      ST_TRIM: rsp.valid = over && (count > CNT_W'(1));
      ST_CLOSE: begin
        rsp.valid       = 1'b1;
        rsp.kind        = KIND_CLOSE;
        rsp.status      = status;
        rsp.total_bytes = total;
        rsp.last        = 1'b1;
        {rsp.out_w3, rsp.out_w2, rsp.out_w1, rsp.out_w0} = key;
      end
      default: rsp.valid = 1'b0;
    endcase
  end

endmodule

// File: sim/lbb_checker.sv
// Scoreboard for the LRU byte-budget cache table: watches both channels and the
// APB port, predicts every response transaction and compares. Depends on lbb_pkg, lbb_ifs.
module lbb_checker import lbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lbb_req_if                req,
  lbb_rsp_if                rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                fails,
  output int                pending
);

  typedef struct packed {
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } rsp_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [SIZE_BITS-1:0] bytes;
  } cached_t;

  rsp_item_t            want_q[$];
  cached_t              lru_order[$]; // front is the least recently used
  logic [63:0]          held;
  logic [LIMIT_W-1:0]   budget_mib;

  assign pending = want_q.size();

  task automatic post(input logic kind, input logic [KEY_W-1:0] k, input logic [1:0] st,
                      input logic lst);
    rsp_item_t r;
    r.kind = kind; r.key = k; r.status = st; r.total = held[TOTAL_W-1:0]; r.last = lst;
    want_q.push_back(r);
  endtask

  task automatic register_key(input logic [KEY_W-1:0] k, input logic [SIZE_BITS-1:0] sz);
    int      hit;
    bit      kept;
    cached_t e;
    cached_t victim;
    hit = -1;
    kept = 1;
    if (k == '0) begin
      post(KIND_CLOSE, k, STATUS_ZERO_KEY, 1'b1);
      return;
    end
    foreach (lru_order[i]) if (lru_order[i].key == k) hit = i;
    if (hit >= 0) begin
      e = lru_order[hit];
      lru_order.delete(hit);
      lru_order.push_back(e);
    end else begin
      // full table: make room first, regardless of budget
      if (lru_order.size() == ENTRIES) begin
        victim = lru_order.pop_front();
        held -= victim.bytes;
        post(KIND_EVICT, victim.key, STATUS_HELD, 1'b0);
      end
      e.key = k;
      e.bytes = sz;
      lru_order.push_back(e);
      held += sz;
    end
    while (budget_mib != 0 && held > (64'(budget_mib) << MIB_SHIFT)) begin
      victim = lru_order.pop_front();
      held -= victim.bytes;
      // the key itself goes last and is folded into the closing result
      if (victim.key == k) begin
        kept = 0;
        break;
      end
      post(KIND_EVICT, victim.key, STATUS_HELD, 1'b0);
    end
    post(KIND_CLOSE, k, kept ? STATUS_HELD : STATUS_TOOSMALL, 1'b1);
  endtask

  always @(posedge clk) begin
    rsp_item_t got;
    rsp_item_t exp_r;
    if (rst) begin
      lru_order.delete();
      want_q.delete();
      held = '0;
      budget_mib <= '0;
      fails <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_W'(REG_LIMIT * 4))
        budget_mib <= pwdata[LIMIT_W-1:0];
      if (req.valid && req.ready)
        register_key({req.key_w3, req.key_w2, req.key_w1, req.key_w0}, req.object_bytes);
      if (rsp.valid && rsp.ready) begin
        got.kind = rsp.kind;
        got.key = {rsp.out_w3, rsp.out_w2, rsp.out_w1, rsp.out_w0};
        got.status = rsp.status;
        got.total = rsp.total_bytes;
        got.last = rsp.last;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected response, exp none, act kind=%0d key=%h", $time,
                   got.kind, got.key);
          fails <= fails + 1;
        end else begin
          exp_r = want_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch exp kind=%0d key=%h status=%0d total=%0d last=%0d",
                     $time, exp_r.kind, exp_r.key, exp_r.status, exp_r.total, exp_r.last);
            $display("%0t:          act kind=%0d key=%h status=%0d total=%0d last=%0d",
                     $time, got.kind, got.key, got.status, got.total, got.last);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// File: sim/testbench.sv
// Top of the cache table testbench: clock, reset, stimulus, APB writes and verdict.
// Depends on lbb_pkg, lbb_ifs, lbb_checker and the lru_byte_budget_cache_table RTL.
module testbench import lbb_pkg::*;;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 20000;

  logic              clk;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fails;
  int                pending;
  int                idle_cycles;
  logic [KEY_W-1:0]  key_pool [48];

  lbb_req_if req_ch ();
  lbb_rsp_if rsp_ch ();

  lru_byte_budget_cache_table DUT (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lbb_checker scoreboard (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fails(fails), .pending(pending)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Pick a gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Response backpressure: random stalls, with stretches of none.
  always @(negedge clk) begin
    int hold;
    if (rst) begin
      hold = 0;
      rsp_ch.ready = 1'b0;
    end else if (hold > 0) begin
      hold--;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = 1'b1;
      if ($urandom_range(0, 3) == 0) hold = pick_gap();
    end
  end

  // Watchdog: abort when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drive one request transaction and hold it until accepted; starts and ends at negedge.
  task automatic send(input logic [KEY_W-1:0] k, input logic [OBJ_W-1:0] sz);
    int  gap;
    bit  took;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    {req_ch.key_w3, req_ch.key_w2, req_ch.key_w1, req_ch.key_w0} = k;
    req_ch.object_bytes = sz;
    req_ch.valid = 1'b1;
    forever begin
      @(posedge clk);
      took = req_ch.ready;
      @(negedge clk);
      if (took) break;
    end
  endtask

  // Hold off until every expected response has arrived, plus the block's tail latency.
  task automatic drain();
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] mib);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = ADDR_W'(REG_LIMIT * 4); pwdata = DATA_W'(mib);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    for (int w = 0; w < 8; w++) k[w*32 +: 32] = $urandom;
    return k;
  endfunction

  // Mostly sizes near the budgets, some zero and some over the full range.
  function automatic logic [OBJ_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return OBJ_W'({$urandom, $urandom});
    return OBJ_W'($urandom_range(0, 1 << 21));
  endfunction

  task automatic random_phase(input logic [LIMIT_W-1:0] mib, input int count);
    int               r;
    logic [KEY_W-1:0] k;
    drain();
    write_limit(mib);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5) k = '0;
      else if (r < 65) k = key_pool[$urandom_range(0, 47)];
      else k = rand_key();
      send(k, rand_size());
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_ch.valid = 1'b0; req_ch.key_w0 = '0; req_ch.key_w1 = '0;
    req_ch.key_w2 = '0; req_ch.key_w3 = '0; req_ch.object_bytes = '0;
    foreach (key_pool[i]) key_pool[i] = rand_key();
    key_pool[0] = {192'd0, 64'd1}; // single low bit
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed: zero key, all-ones key at max size, a repeat hit, then twenty more keys.
    write_limit('0);
    send('0, '1);
    send('1, '1);
    send('1, 40'd5);
    send(key_pool[0], '0);
    for (int i = 1; i <= 19; i++) send(key_pool[i], OBJ_W'(i * 1000));
    drain();
    // Table is at 21 entries; eleven more fill every slot.
    write_limit('0);
    for (int i = 20; i <= 30; i++) send(key_pool[i], OBJ_W'(i));
    // Lower the budget: next hit evicts until it fits; then an oversized key evicts itself.
    drain();
    write_limit(LIMIT_W'(1));
    send(key_pool[30], 40'd1);
    send(key_pool[31], 40'd3 << MIB_SHIFT);
    send(key_pool[32], (40'd1 << MIB_SHIFT) + 1);
    send(key_pool[33], 40'd1 << MIB_SHIFT);

    random_phase(LIMIT_W'(1048576), 60);
    random_phase(LIMIT_W'(16), 80);
    random_phase(LIMIT_W'(2), 60);
    random_phase(LIMIT_W'(1), 50);
    random_phase(LIMIT_W'(7), 40);
    random_phase('0, 65);

    drain();
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
